>>> src/trilinear_donor_stencil_weights_defines.svh
// assertion macros for the trilinear donor stencil weights block
// included by the top level; no other dependencies
`ifndef TRILINEAR_DONOR_STENCIL_WEIGHTS_DEFINES_SVH
`define TRILINEAR_DONOR_STENCIL_WEIGHTS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TDSW_ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("tdsw same-cycle check failed");

// next-cycle implication, disabled in reset
`define TDSW_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("tdsw next-cycle check failed");

`endif

>>> src/tdsw_pkg.sv
// shared types and constants for the trilinear donor stencil weights block
// no dependencies
`timescale 1ns / 1ps

package tdsw_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [16:0] Q_HALF         = 17'd32768;
  localparam logic [16:0] Q_ONE_AND_HALF = 17'd98304;
  localparam logic [2:0]  NODE_LAST      = 3'd7;

  typedef enum logic [1:0] {
    REG_GRID_X = 2'd0,
    REG_GRID_Y = 2'd1,
    REG_GRID_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic [15:0] cell_z;
    logic [15:0] frac_x;
    logic [15:0] frac_y;
    logic [15:0] frac_z;
  } in_t;

  typedef struct packed {
    logic [15:0] node_x;
    logic [15:0] node_y;
    logic [15:0] node_z;
    logic [16:0] weight;
    logic [2:0]  node_number;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } grid_t;

  // clamped node pair and basis pair of one axis
  typedef struct packed {
    logic [15:0] n0;
    logic [15:0] n1;
    logic [16:0] b0;
    logic [16:0] b1;
  } axis_t;

  typedef struct packed {
    axis_t ax;
    axis_t ay;
    axis_t az;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> src/trilinear_donor_stencil_weights.sv
// top level of the trilinear donor stencil weights block
// depends on tdsw_pkg, tdsw_front, tdsw_queue, tdsw_back and the defines header
//
// channel   direction  handshake                     payload
// input     in         start && !busy                in_item (tdsw_pkg::in_t)
// result    out        out_valid, one cycle a node   out_item (tdsw_pkg::out_t)
// config    in         psel && penable && pwrite     pwdata[15:0] at paddr[3:2]
//
// each item yields eight results on consecutive cycles, the first one leaving
// after the queue entry, the back sequencer registers and stages a, b and c
// sustained rate is set by the back sequencer, which
// walks one stencil node per cycle through its two-multiplier weight pipeline
// reset (synchronous, rst_n low) empties the queue and sets every grid size to 1
// busy rises only when the two-entry queue is full; the receiver cannot stall
`timescale 1ns / 1ps
`include "trilinear_donor_stencil_weights_defines.svh"

module trilinear_donor_stencil_weights (
  input  logic             clk,
  input  logic             rst_n,
  // query channel
  input  logic             start,
  output logic             busy,
  input  tdsw_pkg::in_t    in_item,
  // result channel
  output logic             out_valid,
  output tdsw_pkg::out_t   out_item,
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // grid size registers
  tdsw_pkg::grid_t   grid_r, grid_nxt;
  logic              cfg_wr;

  // front to queue to back
  tdsw_pkg::entry_t  fe_entry;
  tdsw_pkg::entry_t  q_data;
  tdsw_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register writes, index three is ignored
  always_comb begin
    grid_nxt = grid_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        tdsw_pkg::REG_GRID_X: grid_nxt.x = pwdata[15:0];
        tdsw_pkg::REG_GRID_Y: grid_nxt.y = pwdata[15:0];
        tdsw_pkg::REG_GRID_Z: grid_nxt.z = pwdata[15:0];
        default:              grid_nxt   = grid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r.x <= 16'd1;
      grid_r.y <= 16'd1;
      grid_r.z <= 16'd1;
    end else begin
      grid_r <= grid_nxt;
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      tdsw_pkg::REG_GRID_X: prdata = {16'd0, grid_r.x};
      tdsw_pkg::REG_GRID_Y: prdata = {16'd0, grid_r.y};
      tdsw_pkg::REG_GRID_Z: prdata = {16'd0, grid_r.z};
      default:              prdata = 32'd0;
    endcase
  end

  // an item enters the queue on the accepting edge
  assign busy = q_stat.full;
  assign push = start && !busy;

  tdsw_front u_front (
    .in_item (in_item),
    .grid    (grid_r),
    .entry   (fe_entry)
  );

  tdsw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (fe_entry),
    .pop       (pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  tdsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // the last flag marks node seven only
  `TDSW_ASSERT_NOW(a_last_node, clk, rst_n, out_valid, out_item.last == (out_item.node_number == tdsw_pkg::NODE_LAST))
  // the nodes of one stencil come on consecutive cycles
  `TDSW_ASSERT_NEXT(a_stencil_run, clk, rst_n, out_valid && !out_item.last, out_valid && (out_item.node_number == $past(out_item.node_number) + 3'd1))
  // a rounded weight never exceeds one
  `TDSW_ASSERT_NOW(a_weight_max, clk, rst_n, out_valid, out_item.weight <= 17'd65536)

endmodule

>>> src/tdsw_front.sv
// front part: classifies one query per axis into clamped nodes and bases
// depends on tdsw_pkg
`timescale 1ns / 1ps

module tdsw_front (
  input  tdsw_pkg::in_t    in_item,
  input  tdsw_pkg::grid_t  grid,
  output tdsw_pkg::entry_t entry
);

  function automatic logic [15:0] clamp_node(input logic signed [17:0] v,
                                             input logic signed [17:0] hi);
    logic signed [17:0] r;
    begin
      r = v;
      if (r > hi) r = hi;
      if (r < 18'sd0) r = 18'sd0;
      return r[15:0];
    end
  endfunction

  function automatic tdsw_pkg::axis_t axis_calc(input logic [15:0] cell_idx,
                                                input logic [15:0] frac,
                                                input logic [15:0] size);
    tdsw_pkg::axis_t    a;
    logic signed [17:0] s;
    logic signed [17:0] hi;
    logic [16:0]        f;
    begin
      f  = {1'b0, frac};
      hi = signed'({2'b00, size}) - 18'sd1;
      if (frac[15]) begin
        s    = signed'({2'b00, cell_idx});
        a.b0 = tdsw_pkg::Q_ONE_AND_HALF - f;
        a.b1 = f - tdsw_pkg::Q_HALF;
      end else begin
        s    = signed'({2'b00, cell_idx}) - 18'sd1;
        a.b0 = tdsw_pkg::Q_HALF - f;
        a.b1 = tdsw_pkg::Q_HALF + f;
      end
      a.n0 = clamp_node(s, hi);
      a.n1 = clamp_node(s + 18'sd1, hi);
      return a;
    end
  endfunction

  always_comb begin
    entry.ax = axis_calc(in_item.cell_x, in_item.frac_x, grid.x);
    entry.ay = axis_calc(in_item.cell_y, in_item.frac_y, grid.y);
    entry.az = axis_calc(in_item.cell_z, in_item.frac_z, grid.z);
  end

endmodule

>>> src/tdsw_queue.sv
// short queue between front and back parts
// depends on tdsw_pkg
`timescale 1ns / 1ps

module tdsw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tdsw_pkg::entry_t   push_data,
  input  logic               pop,
  output tdsw_pkg::entry_t   pop_data,
  output tdsw_pkg::q_stat_t  stat
);

  localparam int unsigned CNT_W = $clog2(tdsw_pkg::QUEUE_DEPTH + 1);

  tdsw_pkg::entry_t                mem_r [tdsw_pkg::QUEUE_DEPTH];
  logic [tdsw_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tdsw_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  always_comb begin
    stat.empty = (cnt_r == CNT_W'(0));
    stat.full  = (cnt_r == CNT_W'(tdsw_pkg::QUEUE_DEPTH));
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    // depth is a power of two, pointers wrap on overflow
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    pop_data   = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/tdsw_back.sv
// back part: walks the eight stencil nodes and forms rounded weights
// depends on tdsw_pkg
`timescale 1ns / 1ps

module tdsw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tdsw_pkg::q_stat_t q_stat,
  input  tdsw_pkg::entry_t  q_data,
  output logic              pop,
  output logic              out_valid,
  output tdsw_pkg::out_t    out_item
);

  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [2:0]  num;
    logic        last;
  } meta_t;

  localparam logic [50:0] ROUND_ADD = 51'h0_8000_0000;

  tdsw_pkg::entry_t cur_r, cur_nxt;
  logic             act_r, act_nxt;
  logic [2:0]       cnt_r, cnt_nxt;

  logic             a_vld_r;
  logic [33:0]      a_pzy_r;
  logic [16:0]      a_bx_r;
  meta_t            a_meta_r, a_meta_nxt;

  logic             b_vld_r;
  logic [50:0]      b_prod_r;
  meta_t            b_meta_r;

  logic [16:0]      bx_sel, by_sel, bz_sel;
  logic [50:0]      rnd_sum;
  logic             out_vld_r;
  tdsw_pkg::out_t   out_r;

  always_comb begin
    pop     = !q_stat.empty && (!act_r || cnt_r == tdsw_pkg::NODE_LAST);
    act_nxt = pop ? 1'b1 : ((cnt_r == tdsw_pkg::NODE_LAST) ? 1'b0 : act_r);
    cnt_nxt = pop ? 3'd0 : (act_r ? cnt_r + 3'd1 : cnt_r);
    cur_nxt = pop ? q_data : cur_r;

    // x fastest, then y, then z
    bx_sel = cnt_r[0] ? cur_r.ax.b1 : cur_r.ax.b0;
    by_sel = cnt_r[1] ? cur_r.ay.b1 : cur_r.ay.b0;
    bz_sel = cnt_r[2] ? cur_r.az.b1 : cur_r.az.b0;

    a_meta_nxt.nx   = cnt_r[0] ? cur_r.ax.n1 : cur_r.ax.n0;
    a_meta_nxt.ny   = cnt_r[1] ? cur_r.ay.n1 : cur_r.ay.n0;
    a_meta_nxt.nz   = cnt_r[2] ? cur_r.az.n1 : cur_r.az.n0;
    a_meta_nxt.num  = cnt_r;
    a_meta_nxt.last = (cnt_r == tdsw_pkg::NODE_LAST);

    rnd_sum = b_prod_r + ROUND_ADD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      cnt_r     <= 3'd0;
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      act_r     <= act_nxt;
      cnt_r     <= cnt_nxt;
      a_vld_r   <= act_r;
      b_vld_r   <= a_vld_r;
      out_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    // stage a: z by y basis product
    a_pzy_r  <= {17'd0, bz_sel} * {17'd0, by_sel};
    a_bx_r   <= bx_sel;
    a_meta_r <= a_meta_nxt;
    // stage b: times x basis
    b_prod_r <= {17'd0, a_pzy_r} * {34'd0, a_bx_r};
    b_meta_r <= a_meta_r;
    // stage c: round half up to q1.16
    out_r.node_x      <= b_meta_r.nx;
    out_r.node_y      <= b_meta_r.ny;
    out_r.node_z      <= b_meta_r.nz;
    out_r.weight      <= rnd_sum[48:32];
    out_r.node_number <= b_meta_r.num;
    out_r.last        <= b_meta_r.last;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

>>> bench/tb_top.sv
// self-checking bench for the trilinear donor stencil weights block
// drives query items and register writes, predicts all eight stencil nodes per item
// depends on tdsw_pkg and the trilinear_donor_stencil_weights top level
`timescale 1ns / 1ps

module tb_top;

  // register index with no register behind it, writes there must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int NODES_PER_ITEM = 8;
  // cycles with no query accepted, no node out and no register access before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // room for the first node to pass the queue and stages a, b and c, and for all eight nodes to follow
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTS = 40;

  // keeps the grid registers and the nodes still owed by the block
  class stencil_checker;
    logic [15:0]    grid_size_cfg[3];
    tdsw_pkg::out_t pending_nodes[$];
    int             errors;

    function new();
      grid_size_cfg = '{16'd1, 16'd1, 16'd1};
      errors = 0;
    endfunction

    function void set_grid(input logic [1:0] idx, input logic [15:0] value);
      grid_size_cfg[idx] = value;
    endfunction

    function int pending();
      return pending_nodes.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    // stencil start and the two linear bases of one axis
    function void axis_split(input logic [15:0] cell_idx, input logic [15:0] frac,
                             output int first, output logic [16:0] b0,
                             output logic [16:0] b1);
      if ({1'b0, frac} >= tdsw_pkg::Q_HALF) begin
        first = int'(cell_idx);
        b0    = tdsw_pkg::Q_ONE_AND_HALF - {1'b0, frac};
        b1    = {1'b0, frac} - tdsw_pkg::Q_HALF;
      end else begin
        first = int'(cell_idx) - 1;
        b0    = tdsw_pkg::Q_HALF - {1'b0, frac};
        b1    = tdsw_pkg::Q_HALF + {1'b0, frac};
      end
    endfunction

    // lower bound wins, so a zero grid pins the axis to node 0
    function logic [15:0] clamp_index(input int pos, input logic [15:0] size);
      int hi;
      int v;
      hi = int'(size) - 1;
      v  = pos;
      if (v > hi) v = hi;
      if (v < 0) v = 0;
      return v[15:0];
    endfunction

    // expand one accepted query into its eight expected nodes
    function void note_query(input tdsw_pkg::in_t q);
      logic [15:0]       cells[3];
      logic [15:0]       fracs[3];
      int                first[3];
      logic [16:0]       b0[3];
      logic [16:0]       b1[3];
      logic [16:0]       bx, by, bz;
      logic [63:0]       prod;
      tdsw_pkg::out_t    node;
      int                i, j, k;
      cells = '{q.cell_x, q.cell_y, q.cell_z};
      fracs = '{q.frac_x, q.frac_y, q.frac_z};
      for (int a = 0; a < 3; a++) begin
        axis_split(cells[a], fracs[a], first[a], b0[a], b1[a]);
      end
      for (int n = 0; n < NODES_PER_ITEM; n++) begin
        i  = n & 1;
        j  = (n >> 1) & 1;
        k  = (n >> 2) & 1;
        bx = i ? b1[0] : b0[0];
        by = j ? b1[1] : b0[1];
        bz = k ? b1[2] : b0[2];
        prod = 64'(bz) * 64'(by) * 64'(bx);
        node.node_x      = clamp_index(first[0] + i, grid_size_cfg[0]);
        node.node_y      = clamp_index(first[1] + j, grid_size_cfg[1]);
        node.node_z      = clamp_index(first[2] + k, grid_size_cfg[2]);
        node.weight      = 17'((prod + 64'h8000_0000) >> 32);
        node.node_number = 3'(n);
        node.last        = (3'(n) == tdsw_pkg::NODE_LAST);
        pending_nodes.push_back(node);
      end
    endfunction

    task check_node(input tdsw_pkg::out_t got);
      tdsw_pkg::out_t want;
      if (pending_nodes.size() == 0) begin
        report($sformatf("node %0d with no query pending", got.node_number));
      end else begin
        want = pending_nodes.pop_front();
        if (got.node_x !== want.node_x)
          report($sformatf("node %0d node_x %0d want %0d", want.node_number,
                           got.node_x, want.node_x));
        if (got.node_y !== want.node_y)
          report($sformatf("node %0d node_y %0d want %0d", want.node_number,
                           got.node_y, want.node_y));
        if (got.node_z !== want.node_z)
          report($sformatf("node %0d node_z %0d want %0d", want.node_number,
                           got.node_z, want.node_z));
        if (got.weight !== want.weight)
          report($sformatf("node %0d weight %0d want %0d", want.node_number,
                           got.weight, want.weight));
        if (got.node_number !== want.node_number)
          report($sformatf("node_number %0d want %0d", got.node_number,
                           want.node_number));
        if (got.last !== want.last)
          report($sformatf("node %0d last %0b want %0b", want.node_number,
                           got.last, want.last));
      end
    endtask

    task check_drained();
      if (pending_nodes.size() != 0)
        report($sformatf("%0d nodes never arrived", pending_nodes.size()));
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  tdsw_pkg::in_t  in_item = '0;
  logic           out_valid;
  tdsw_pkg::out_t out_item;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [3:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  stencil_checker sb;
  int             stall_cycles = 0;

  trilinear_donor_stencil_weights i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both handshakes sampled at the edge that completes them
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_query(in_item);
      if (out_valid) sb.check_node(out_item);
    end
  end

  // hang detector, register traffic counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // hold start until the block takes the item, then optionally go idle
  task automatic send_query(input tdsw_pkg::in_t q, input int gap);
    start   <= 1'b1;
    in_item <= q;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every owed node come out
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // setup then access cycle; upper data bits are junk the block must drop
  task automatic write_grid(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx != REG_UNUSED) sb.set_grid(idx, value);
  endtask

  task automatic set_grids(input logic [15:0] gx, input logic [15:0] gy,
                           input logic [15:0] gz);
    write_grid(tdsw_pkg::REG_GRID_X, gx);
    write_grid(tdsw_pkg::REG_GRID_Y, gy);
    write_grid(tdsw_pkg::REG_GRID_Z, gz);
  endtask

  function automatic tdsw_pkg::in_t mk_query(input logic [15:0] cx,
                                             input logic [15:0] cy,
                                             input logic [15:0] cz,
                                             input logic [15:0] fx,
                                             input logic [15:0] fy,
                                             input logic [15:0] fz);
    tdsw_pkg::in_t q;
    q = '{cell_x: cx, cell_y: cy, cell_z: cz, frac_x: fx, frac_y: fy, frac_z: fz};
    return q;
  endfunction

  // cells lean toward both clamp edges of the current grid
  function automatic logic [15:0] random_cell(input logic [15:0] size);
    int top;
    int v;
    top = (size == 0) ? 0 : int'(size) - 1;
    case ($urandom_range(3))
      0: v = $urandom_range(65534);
      1: v = top + int'($urandom_range(3)) - 1;
      2: v = $urandom_range(2);
      default: v = $urandom_range(top);
    endcase
    if (v < 0) v = 0;
    if (v > 65534) v = 65534;
    return v[15:0];
  endfunction

  // fractions hit the half-cell split and the range ends often
  function automatic logic [15:0] random_frac();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 16'd0;
          1: return 16'd32767;
          2: return 16'd32768;
          default: return 16'd65535;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tdsw_pkg::in_t random_query();
    return mk_query(random_cell(sb.grid_size_cfg[0]), random_cell(sb.grid_size_cfg[1]),
                    random_cell(sb.grid_size_cfg[2]), random_frac(), random_frac(),
                    random_frac());
  endfunction

  // idle_pct is the chance of a sender gap after each item;
  // pause_at lets the pipeline empty completely once mid-phase
  task automatic run_phase(input int count, input int idle_pct, input int pause_at);
    int gap;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) wait_drained();
      gap = (int'($urandom_range(99)) < idle_pct) ? int'($urandom_range(1, 12)) : 0;
      send_query(random_query(), gap);
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid of one cell per axis, before any register write
    send_query(mk_query(16'd0, 16'd0, 16'd0, 16'd0, 16'd32768, 16'd65535), 0);
    send_query(mk_query(16'd65534, 16'd1, 16'd0, 16'd32767, 16'd0, 16'd32768), 3);
    wait_drained();

    // small grid: cell below zero, top clamp, far beyond grid
    set_grids(16'd4, 16'd4, 16'd4);
    send_query(mk_query(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 0);
    send_query(mk_query(16'd0, 16'd0, 16'd0, 16'd32767, 16'd32768, 16'd65535), 0);
    send_query(mk_query(16'd3, 16'd3, 16'd3, 16'd32768, 16'd32768, 16'd32768), 0);
    send_query(mk_query(16'd3, 16'd2, 16'd1, 16'd65535, 16'd65535, 16'd65535), 0);
    send_query(mk_query(16'd65534, 16'd65534, 16'd65534, 16'd1, 16'd40000,
                        16'd12345), 2);
    send_query(mk_query(16'd4, 16'd0, 16'd65534, 16'd32767, 16'd65535, 16'd0), 0);
    send_query(mk_query(16'hAAAA, 16'h5555, 16'd2, 16'h5555, 16'hAAAA, 16'd1), 5);
    wait_drained();

    // a write to the unused index must leave the grid alone
    write_grid(REG_UNUSED, 16'd9);
    send_query(mk_query(16'd3, 16'd4, 16'd5, 16'd32768, 16'd0, 16'd65535), 0);
    wait_drained();

    // zero grid pins every axis to node 0
    set_grids(16'd0, 16'd0, 16'd0);
    send_query(mk_query(16'd0, 16'd7, 16'd65534, 16'd0, 16'd32768, 16'd65535), 0);
    send_query(mk_query(16'd1, 16'd0, 16'd300, 16'd32767, 16'd100, 16'd50000), 0);
    wait_drained();

    // largest grid, indices pass through unclamped except below zero and above 65534
    set_grids(16'd65535, 16'd65535, 16'd65535);
    send_query(mk_query(16'd65534, 16'd65534, 16'd65534, 16'd65535, 16'd65535,
                        16'd65535), 0);
    send_query(mk_query(16'd0, 16'd65534, 16'd1, 16'd0, 16'd32768, 16'd32767), 0);
    send_query(mk_query(16'd32768, 16'd0, 16'd65533, 16'd32768, 16'd0, 16'd1), 1);
    wait_drained();

    // random phases across grid settings and sender idling
    set_grids(16'd6, 16'd3, 16'd2);
    run_phase(120, 0, -1);
    set_grids(16'd65535, 16'd65535, 16'd65535);
    run_phase(120, 63, 60);
    set_grids(16'd0, 16'd1, 16'd500);
    run_phase(120, 0, -1);
    write_grid(REG_UNUSED, 16'd0);
    set_grids(16'd40000, 16'd0, 16'd7);
    run_phase(120, 29, -1);

    // catch any stray nodes after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/tdsw_pkg.sv
src/tdsw_front.sv
src/tdsw_queue.sv
src/tdsw_back.sv
src/trilinear_donor_stencil_weights.sv
bench/tb_top.sv
